>>> sv/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box cull core
// Plane register layout, fixed-point formats and the per-beat control record
// that travels along the chain of plane cells.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int NORMAL_W    = 16;  // Q2.14 normal component
    localparam int NORMAL_FRAC = 14;
    localparam int DIST_W      = 16;
    localparam int PLANE_W     = 64;  // packed plane register
    localparam int PLANE_REGS  = 6;   // planes that have a register
    localparam int CFG_IDX_W   = 3;
    localparam int AXES        = 3;
    // -(d * 2^14) spans [-(2^29 - 2^14), 2^29]
    localparam int NEG_DIST_W  = DIST_W + NORMAL_FRAC + 1;

    // Field slots inside a plane register
    localparam int SLOT_NX   = 0;
    localparam int SLOT_NY   = 1;
    localparam int SLOT_NZ   = 2;
    localparam int SLOT_DIST = 3;

    typedef struct packed {
        logic valid;
        logic visible;
    } fbc_ctrl_t;

endpackage

>>> sv/fbc_cell.sv
// ----------------------------------------------------------------------------
// fbc_cell: one clipping plane of the cull chain
// Holds a plane, picks the positive vertex of the passing box, multiplies it
// with the normal (first stage), sums and compares with the negated distance
// (second stage), and clears the visible flag on a reject.
// ----------------------------------------------------------------------------
module fbc_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         plane_we,
    input  logic [fbc_pkg::PLANE_W-1:0]                  plane_data,
    input  fbc_pkg::fbc_ctrl_t                           ctl_in,
    input  logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    lo_in,
    input  logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    hi_in,
    output fbc_pkg::fbc_ctrl_t                           ctl_out,
    output logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    lo_out,
    output logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    hi_out
);

    localparam int PROD_W = COORD_WIDTH + fbc_pkg::NORMAL_W;
    localparam int SUM_W  = (PROD_W + 2 > fbc_pkg::NEG_DIST_W + 1) ?
                            PROD_W + 2 : fbc_pkg::NEG_DIST_W + 1;

    logic [fbc_pkg::AXES-1:0][fbc_pkg::NORMAL_W-1:0] normal_reg;
    logic signed [fbc_pkg::NEG_DIST_W-1:0]           neg_dist_reg;
    logic signed [fbc_pkg::NEG_DIST_W-1:0]           neg_dist_next;
    logic signed [fbc_pkg::DIST_W-1:0]               plane_dist;

    fbc_pkg::fbc_ctrl_t                              ctl_a_reg;
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]       lo_a_reg;
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]       hi_a_reg;
    logic signed [PROD_W-1:0]                        prod_reg  [fbc_pkg::AXES];
    logic signed [PROD_W-1:0]                        prod_next [fbc_pkg::AXES];

    fbc_pkg::fbc_ctrl_t                              ctl_reg;
    fbc_pkg::fbc_ctrl_t                              ctl_next;
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]       lo_reg;
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]       hi_reg;
    logic signed [SUM_W-1:0]                         dot_sum;
    logic                                            reject;

    // Store the negated, rescaled distance so the compare stage stays short
    assign plane_dist = signed'(plane_data[fbc_pkg::SLOT_DIST*16 +: fbc_pkg::DIST_W]);
    assign neg_dist_next = -(fbc_pkg::NEG_DIST_W'(plane_dist) <<< fbc_pkg::NORMAL_FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg   <= '0;
            neg_dist_reg <= '0;
        end
        else if (plane_we)
        begin
            normal_reg[0] <= plane_data[fbc_pkg::SLOT_NX*16 +: fbc_pkg::NORMAL_W];
            normal_reg[1] <= plane_data[fbc_pkg::SLOT_NY*16 +: fbc_pkg::NORMAL_W];
            normal_reg[2] <= plane_data[fbc_pkg::SLOT_NZ*16 +: fbc_pkg::NORMAL_W];
            neg_dist_reg  <= neg_dist_next;
        end
    end

    // Positive vertex: max corner where the normal is non-negative
    always_comb
    begin
        for (int a = 0; a < fbc_pkg::AXES; a++)
        begin
            if (normal_reg[a][fbc_pkg::NORMAL_W-1])
                prod_next[a] = PROD_W'(signed'(normal_reg[a])) * PROD_W'(signed'(lo_in[a]));
            else
                prod_next[a] = PROD_W'(signed'(normal_reg[a])) * PROD_W'(signed'(hi_in[a]));
        end
    end

    assign dot_sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
    assign reject  = dot_sum < SUM_W'(neg_dist_reg);

    always_comb
    begin
        ctl_next.valid   = ctl_a_reg.valid;
        ctl_next.visible = ctl_a_reg.visible & ~reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_reg   <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg <= lo_in;
            hi_a_reg <= hi_in;
            for (int a = 0; a < fbc_pkg::AXES; a++)
                prod_reg[a] <= prod_next[a];
            lo_reg   <= lo_a_reg;
            hi_reg   <= hi_a_reg;
        end
    end

    assign ctl_out = ctl_reg;
    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;

`ifndef NO_ASSERTIONS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctl_reg) && $stable(ctl_a_reg))
        else $error("cell control moved while the chain was held");

    a_reject_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        en && ctl_a_reg.valid && !ctl_a_reg.visible |=> !ctl_reg.visible)
        else $error("a culled beat became visible again");

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> ctl_reg.valid == $past(ctl_a_reg.valid))
        else $error("beat lost or invented between cell stages");
`endif

endmodule

>>> sv/frustum_box_cull_core.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_core: p-vertex frustum test of axis-aligned boxes
// A chain of plane cells; each cell tests the box against its plane and
// passes the box and the running visible flag to the next cell.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   box in   | box_valid / box_stall  | box_min_x..z, box_max_x..z
//   result   | res_valid / res_stall  | visible
//   config   | cfg_we                 | cfg_index, cfg_data (64-bit plane)
//
// One box per cycle is taken while box_stall is low; each plane cell adds
// two register stages (multiply, then sum and compare).
// Reset clears all planes to zero, which makes every box visible.
// A stalled result holds the whole chain; box_stall rises only while a
// result is waiting and res_stall is high.
// ----------------------------------------------------------------------------
module frustum_box_cull_core #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbc_pkg::PLANE_W-1:0]       cfg_data,

    input  logic                              box_valid,
    output logic                              box_stall,
    input  logic signed [COORD_WIDTH-1:0]     box_min_x,
    input  logic signed [COORD_WIDTH-1:0]     box_min_y,
    input  logic signed [COORD_WIDTH-1:0]     box_min_z,
    input  logic signed [COORD_WIDTH-1:0]     box_max_x,
    input  logic signed [COORD_WIDTH-1:0]     box_max_y,
    input  logic signed [COORD_WIDTH-1:0]     box_max_z,

    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              visible
);

    fbc_pkg::fbc_ctrl_t                           ctl [NUM_PLANES+1];
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    lo  [NUM_PLANES+1];
    logic [fbc_pkg::AXES-1:0][COORD_WIDTH-1:0]    hi  [NUM_PLANES+1];
    logic                                         en;

    // Advance everything unless a finished result is being held
    assign en        = ~(ctl[NUM_PLANES].valid & res_stall);
    assign box_stall = ~en;

    assign ctl[0].valid   = box_valid;
    assign ctl[0].visible = 1'b1;
    assign lo[0] = {box_min_z, box_min_y, box_min_x};
    assign hi[0] = {box_max_z, box_max_y, box_max_x};

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        logic plane_we;

        if (i < fbc_pkg::PLANE_REGS)
        begin : g_reg
            assign plane_we = cfg_we && (cfg_index == fbc_pkg::CFG_IDX_W'(i));
        end
        else
        begin : g_noreg
            // no register: plane stays zero and never rejects
            assign plane_we = 1'b0;
        end

        fbc_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .plane_we   (plane_we),
            .plane_data (cfg_data),
            .ctl_in     (ctl[i]),
            .lo_in      (lo[i]),
            .hi_in      (hi[i]),
            .ctl_out    (ctl[i+1]),
            .lo_out     (lo[i+1]),
            .hi_out     (hi[i+1])
        );
    end

    assign res_valid = ctl[NUM_PLANES].valid;
    assign visible   = ctl[NUM_PLANES].visible;

`ifndef NO_ASSERTIONS
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        box_stall |-> res_valid && res_stall)
        else $error("input stalled with no result held");

    a_free_output_flows: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !box_stall)
        else $error("input stalled while the output stage was empty");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(visible))
        else $error("stalled result beat changed");
`endif

endmodule
